@@ rtl/mandelbrot_escape_counter_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the escape counter
// Shared concurrent check wrappers; every user has clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_COUNTER_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_COUNTER_TOP_MACROS_SVH

// Check that is off while reset is high.
`define MEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that also runs through reset.
`define MEC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/mec_pkg.sv @@
// ----------------------------------------------------------------------------
// mec_pkg
// Shared widths, constants and control types of the escape counter.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ITER_LIMIT_DEF  = 256;

  localparam int INNER_FRAC = 29;         // fraction bits of z and c
  localparam int C_W        = 32;         // inner c: sign, 2 int, 29 frac
  localparam int ZM_W       = 31;         // non-escaped z: |z| < 2
  localparam int Z_W        = 34;         // updated z: |z| < 12
  localparam int P_W        = 2 * ZM_W;   // product of two z parts
  localparam int S_W        = P_W + 1;    // sum or difference of products

  localparam int MAXIT_W     = 9;
  localparam int COUNT_OUT_W = 9;
  localparam logic [MAXIT_W-1:0] MAXIT_RESET = 9'd256;

  // controller -> datapath
  typedef struct packed {
    logic load;    // take a new point and limit, clear products and count
    logic update;  // z = z^2 + c, count + 1
    logic square;  // form re^2, im^2, re*im of z
    logic emit;    // hand the count to the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mag_esc; // registered squares give |z|^2 >= 4
    logic stop;    // update in flight leaves |re| or |im| >= 2, or hits limit
  } sts_t;

endpackage

@@ rtl/mec_ctrl.sv @@
// ----------------------------------------------------------------------------
// mec_ctrl
// Sequencer: load, then alternate update and square until escape or limit.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_counter_top_macros.svh"

module mec_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_free,
  input  mec_pkg::sts_t sts,
  output mec_pkg::cmd_t cmd
);
  import mec_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        // magnitude escape of the current z ends the point as is
        if (sts.mag_esc) begin
          state_next = S_DONE;
        end else begin
          cmd.update = 1'b1;
          state_next = sts.stop ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cmd.square = 1'b1;
        state_next = S_ADD;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `MEC_ASSERT(a_mul_then_add, state == S_MUL |=> state == S_ADD, "square not followed by update")
  `MEC_ASSERT(a_emit_to_idle, cmd.emit |=> state == S_IDLE, "emit did not return to idle")
  `MEC_ASSERT(a_idle_quiet, in_ready |-> !cmd.update && !cmd.square, "datapath busy while idle")

endmodule

@@ rtl/mec_datapath.sv @@
// ----------------------------------------------------------------------------
// mec_datapath
// Point registers, z iterate, three squaring multipliers, step counter.
// ----------------------------------------------------------------------------
module mec_datapath #(
  parameter int COORD_WIDTH = mec_pkg::COORD_WIDTH_DEF,
  parameter int ITER_LIMIT  = mec_pkg::ITER_LIMIT_DEF
) (
  input  logic                                 clk,
  input  mec_pkg::cmd_t                        cmd,
  output mec_pkg::sts_t                        sts,
  input  logic signed [COORD_WIDTH-1:0]        c_real,
  input  logic signed [COORD_WIDTH-1:0]        c_imag,
  input  logic [mec_pkg::MAXIT_W-1:0]          max_iterations,
  output logic [mec_pkg::COUNT_OUT_W-1:0]      step_count
);
  import mec_pkg::*;

  localparam int CNT_W = $clog2(ITER_LIMIT + 1);
  localparam logic signed [Z_W-1:0] TWO     = Z_W'(64'sd2 <<< INNER_FRAC);
  localparam logic signed [Z_W-1:0] NEG_TWO = -TWO;
  localparam logic signed [S_W-1:0] FOUR_SQ = S_W'(64'sd4 <<< (2 * INNER_FRAC));

  logic signed [C_W-1:0]  cr_in, ci_in, cr, ci;
  logic signed [Z_W-1:0]  zr, zi, zr_next, zi_next;
  logic signed [ZM_W-1:0] zm_r, zm_i;
  logic signed [P_W-1:0]  rr, ii, ri, rr_prod, ii_prod, ri_prod;
  logic signed [S_W-1:0]  diff, twice_ri, mag;
  logic [CNT_W-1:0]       count, count_inc, limit, limit_in;
  logic                   range_esc;

  // bring the coordinates to 29 fraction bits (floor when narrowing)
  generate
    if (COORD_WIDTH < C_W) begin : g_widen
      assign cr_in = {c_real, {(C_W - COORD_WIDTH){1'b0}}};
      assign ci_in = {c_imag, {(C_W - COORD_WIDTH){1'b0}}};
    end else begin : g_narrow
      assign cr_in = C_W'(c_real >>> (COORD_WIDTH - C_W));
      assign ci_in = C_W'(c_imag >>> (COORD_WIDTH - C_W));
    end
  endgenerate

  // limit 0 acts as 1, above ITER_LIMIT clips
  always_comb begin
    if (max_iterations == '0) begin
      limit_in = CNT_W'(1);
    end else if (int'(max_iterations) > ITER_LIMIT) begin
      limit_in = CNT_W'(ITER_LIMIT);
    end else begin
      limit_in = CNT_W'(max_iterations);
    end
  end

  // z^2 + c from the registered products, floor shift by the fraction
  assign diff      = S_W'(rr) - S_W'(ii);
  assign twice_ri  = S_W'(ri) <<< 1;
  assign zr_next   = Z_W'(diff >>> INNER_FRAC) + Z_W'(cr);
  assign zi_next   = Z_W'(twice_ri >>> INNER_FRAC) + Z_W'(ci);
  assign count_inc = count + CNT_W'(1);
  assign range_esc = (zr_next >= TWO) || (zr_next <= NEG_TWO) ||
                     (zi_next >= TWO) || (zi_next <= NEG_TWO);

  assign mag         = S_W'(rr) + S_W'(ii);
  assign sts.mag_esc = (mag >= FOUR_SQ);
  assign sts.stop    = range_esc || (count_inc >= limit);

  // z has not escaped by range when squared, so it fits ZM_W bits
  assign zm_r    = ZM_W'(zr);
  assign zm_i    = ZM_W'(zi);
  assign rr_prod = zm_r * zm_r;
  assign ii_prod = zm_i * zm_i;
  assign ri_prod = zm_r * zm_i;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr    <= cr_in;
      ci    <= ci_in;
      rr    <= '0;
      ii    <= '0;
      ri    <= '0;
      count <= '0;
      limit <= limit_in;
    end
    if (cmd.update) begin
      zr    <= zr_next;
      zi    <= zi_next;
      count <= count_inc;
    end
    if (cmd.square) begin
      rr <= rr_prod;
      ii <= ii_prod;
      ri <= ri_prod;
    end
  end

  assign step_count = COUNT_OUT_W'(count);

endmodule

@@ rtl/mandelbrot_escape_counter_top.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter_top
// Escape-time counter for one complex point per word.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one word per point, c_real and c_imag as signed
//   fixed point with COORD_WIDTH-3 fraction bits (Q3.29 by default).
// Output stream (m_axis): one word per point, the step count 1 .. limit.
// Config: cfg_wr_en/cfg_wr_data write max_iterations (reset value 256);
//   0 acts as 1, values above ITER_LIMIT clip. Write only while idle.
// Iteration: each step of the iterate loop is one registered pass through
//   three parallel 31x31 squaring multipliers and one add/shift/compare
//   pass that updates z and tests the range. One point is in work at a time.
// The result sits in an output register, so a new point is accepted while
//   the previous count still waits on m_axis_tready. If a result finishes
//   while the register is still full, the sequencer holds it and takes no
//   new point until the register drains.
// Reset (rst, synchronous): sequencer idle, output empty, limit 256.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_counter_top_macros.svh"

module mandelbrot_escape_counter_top #(
  parameter int COORD_WIDTH = mec_pkg::COORD_WIDTH_DEF,
  parameter int ITER_LIMIT  = mec_pkg::ITER_LIMIT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // point word
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [COORD_WIDTH-1:0] c_real, [2*COORD_WIDTH-1:COORD_WIDTH] c_imag, zero pad
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // count word
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [8:0] step_count, [15:9] zero
  output logic [((mec_pkg::COUNT_OUT_W+7)/8)*8-1:0] m_axis_tdata,
  // max_iterations write
  input  logic                                   cfg_wr_en,
  input  logic [mec_pkg::MAXIT_W-1:0]            cfg_wr_data
);
  import mec_pkg::*;

  localparam int OUT_TDATA_W = ((COUNT_OUT_W + 7) / 8) * 8;

  cmd_t                   cmd;
  sts_t                   sts;
  logic [MAXIT_W-1:0]     max_iterations;
  logic [COUNT_OUT_W-1:0] step_count, out_count;
  logic                   out_valid;
  logic                   out_free;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAXIT_RESET;
    end else if (cfg_wr_en) begin
      max_iterations <= cfg_wr_data;
    end
  end

  // output register: emit only when empty or draining this cycle
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count <= step_count;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_count);

  mec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  mec_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .ITER_LIMIT  (ITER_LIMIT)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .c_real         (s_axis_tdata[COORD_WIDTH-1:0]),
    .c_imag         (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .max_iterations (max_iterations),
    .step_count     (step_count)
  );

  `MEC_ASSERT(a_no_overwrite, cmd.emit |-> !m_axis_tvalid || m_axis_tready, "count word overwritten")
  `MEC_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "accepted twice")
  `MEC_ASSERT_ALWAYS(a_reset_state, rst |=> !m_axis_tvalid && s_axis_tready, "reset left block busy")

endmodule

@@ sim/tb_mandelbrot_escape_counter_top.sv @@
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_counter_top
// Self-checking bench for the escape-time counter: point words go in on
// s_axis, and each count word from m_axis is checked against an escape-time
// predictor kept in the bench. The run sweeps several iteration limits, with
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_counter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mec_pkg::*;

  // Watchdog. Take the slowest legal point plus the longest receiver stall
  // and sender gap, times ~650 points, then allow several times that.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned REPORT_CAP  = 10;

  // Q3.29 escape thresholds: |part| >= 2, and |z|^2 >= 4 at 58 frac bits.
  localparam longint ESC_PART = longint'(2) <<< INNER_FRAC;
  localparam longint ESC_MAG  = longint'(4) <<< (2 * INNER_FRAC);

  // Point word layout, lowest bits first: c_real, then c_imag.
  typedef struct packed {
    logic signed [31:0] c_imag;
    logic signed [31:0] c_real;
  } point_t;

  typedef struct {
    point_t     pt;
    logic [8:0] count;
  } pending_count_t;

  // --------------------------------------------------------------------------
  // DUT signals. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata  = '0;  // [31:0] c_real, [63:32] c_imag
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;        // [8:0] step_count, [15:9] zero
  logic                  cfg_wr_en     = 1'b0;
  logic [MAXIT_W-1:0]    cfg_wr_data   = '0;

  // Bench copy of max_iterations. It only changes while the block is idle.
  logic [MAXIT_W-1:0]    limit_cfg     = MAXIT_RESET;

  pending_count_t        pending_counts[$];

  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned points_sent    = 0;
  int unsigned counts_checked = 0;
  int unsigned limit_writes   = 0;
  int unsigned longest_count  = 0;

  // Idle shaping: knobs set by the tests, and the run counters behind them.
  bit          tx_gaps_on     = 1'b0;
  bit          rx_stalls_on   = 1'b0;
  int unsigned tx_burst_left  = 0;
  int unsigned rx_left        = 0;

  mandelbrot_escape_counter_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Escape-time predictor. z starts at 0 and runs z = z^2 + c at 29 frac
  // bits. The squares are exact at 58 frac bits and are floored back to 29
  // (>>> on a signed longint floors). A limit of 0 acts as 1, and anything
  // above the build limit clips to it.
  // --------------------------------------------------------------------------
  function automatic logic [8:0] escape_steps(input point_t p, input logic [8:0] max_it);
    longint      cr, ci, zr, zi, sq_re, sq_im;
    int unsigned lim, steps;
    cr    = longint'(p.c_real);
    ci    = longint'(p.c_imag);
    zr    = 0;
    zi    = 0;
    steps = 0;
    lim   = max_it;
    if (lim == 0) lim = 1;
    if (lim > ITER_LIMIT_DEF) lim = ITER_LIMIT_DEF;
    do begin
      sq_re = (zr * zr - zi * zi) >>> INNER_FRAC;
      sq_im = (2 * (zr * zi)) >>> INNER_FRAC;
      zr    = sq_re + cr;
      zi    = sq_im + ci;
      steps++;
      if (zr >= ESC_PART || zr <= -ESC_PART || zi >= ESC_PART || zi <= -ESC_PART) break;
      if (zr * zr + zi * zi >= ESC_MAG) break;
    end while (steps < lim);
    return steps[8:0];
  endfunction

  function automatic logic signed [31:0] q29(input real v);
    return $rtoi(v * 536870912.0);
  endfunction

  function automatic point_t make_point(input real re, input real im);
    point_t p;
    p.c_real = q29(re);
    p.c_imag = q29(im);
    return p;
  endfunction

  // Random point. Some are raw 32-bit patterns (mostly an escape at step 1,
  // but every bit toggles), most fall in the set's neighborhood, and some
  // sit near the boundary or inside the cardioid so they run long.
  function automatic point_t rand_point();
    point_t      p;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      p.c_real = $urandom;
      p.c_imag = $urandom;
    end else if (pick < 7) begin
      // re in [-2.25, 0.75], im in [-1.25, 1.25]
      p.c_real = int'($urandom_range(0, 1610612736)) - 1207959552;
      p.c_imag = int'($urandom_range(0, 1342177280)) - 671088640;
    end else if (pick < 9) begin
      case ($urandom_range(0, 4))
        0:       p = make_point(0.25, 0.0);
        1:       p = make_point(-0.75, 0.1);
        2:       p = make_point(-0.1, 0.65);
        3:       p = make_point(-1.25, 0.02);
        default: p = make_point(0.285, 0.53);
      endcase
      p.c_real = p.c_real + int'($urandom_range(0, 1 << 21)) - (1 << 20);
      p.c_imag = p.c_imag + int'($urandom_range(0, 1 << 21)) - (1 << 20);
    end else begin
      // re in [-0.5, 0.2], im in [-0.3, 0.3]
      p.c_real = int'($urandom_range(0, 375809638)) - 268435456;
      p.c_imag = int'($urandom_range(0, 322122546)) - 161061273;
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d counts still pending",
               cycle_count, pending_counts.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: always ready, or alternating ready runs and stalls. Long
  // stalls leave the output register full while the next point finishes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_left = 0;
    end else if (!rx_stalls_on) begin
      m_axis_tready <= 1'b1;
    end else if (rx_left != 0) begin
      rx_left--;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      rx_left = $urandom_range(0, 19);
    end else begin
      m_axis_tready <= 1'b1;
      rx_left = $urandom_range(0, 9);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. An accepted point word queues its predicted count, and each
  // accepted count word is checked against the oldest one. The sampled
  // values are the ones from before the edge, since every driver uses NBAs.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pending_count_t exp_cnt;
    point_t         in_pt;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_pt         = point_t'(s_axis_tdata);
        exp_cnt.pt    = in_pt;
        exp_cnt.count = escape_steps(in_pt, limit_cfg);
        pending_counts.push_back(exp_cnt);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_counts.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("unexpected count word %h at cycle %0d", m_axis_tdata, cycle_count);
        end else begin
          exp_cnt = pending_counts.pop_front();
          counts_checked++;
          if (exp_cnt.count > longest_count) longest_count = exp_cnt.count;
          // step_count field, then the zero pad above it
          if (m_axis_tdata[8:0] !== exp_cnt.count || m_axis_tdata[15:9] !== 7'd0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
              $display("count mismatch: c=(%h, %h) expected %0d got %0d (word %h)",
                       exp_cnt.pt.c_real, exp_cnt.pt.c_imag, exp_cnt.count,
                       m_axis_tdata[8:0], m_axis_tdata);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks. Each one starts and ends right after a rising
  // edge.
  // --------------------------------------------------------------------------

  // Send one point word. tvalid stays high between words of a burst, and a gap
  // lowers it before the next word.
  task automatic send_point(input point_t p);
    logic ready_seen;
    if (tx_gaps_on && tx_burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      tx_burst_left = $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    ready_seen = 1'b0;
    // tready is stable mid-cycle, so sample it at the falling edge.
    while (!ready_seen) begin
      @(negedge clk);
      ready_seen = s_axis_tready;
      @(posedge clk);
    end
    if (tx_burst_left != 0) tx_burst_left--;
    points_sent++;
  endtask

  // Stop sending and wait until every queued count has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_counts.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // max_iterations write. Only called once the block is drained.
  task automatic write_limit(input logic [MAXIT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_cfg    = v;
    limit_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset limit (256): corners of the Q3.29 range, exact escape thresholds,
  // points that run to the limit, and alternating bit patterns.
  task automatic test_reset_limit_points();
    point_t p;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    send_point(make_point(0.0, 0.0));           // never escapes
    p.c_real = 32'sh8000_0000; p.c_imag = 32'sh8000_0000;
    send_point(p);                              // most negative corner
    p.c_real = 32'sh7FFF_FFFF; p.c_imag = 32'sh7FFF_FFFF;
    send_point(p);                              // most positive corner
    p.c_real = 32'sh7FFF_FFFF; p.c_imag = 32'sh8000_0000;
    send_point(p);
    send_point(make_point(-2.0, 0.0));          // |re| == 2 exactly
    p.c_real = 32'shC000_0001; p.c_imag = 32'sh0000_0000;
    send_point(p);                              // one lsb inside -2
    send_point(make_point(0.0, 2.0));           // |im| == 2 exactly
    send_point(make_point(1.5, 1.5));           // escapes only via |z|^2
    send_point(make_point(0.25, 0.0));          // cusp of the cardioid
    send_point(make_point(-0.75, 0.0));         // neck between bulbs
    send_point(make_point(-1.0, 0.0));          // orbit alternates between -1 and 0
    p.c_real = 32'sh5555_5555; p.c_imag = 32'shAAAA_AAAA;
    send_point(p);
    p.c_real = 32'shAAAA_AAAA; p.c_imag = 32'sh5555_5555;
    send_point(p);
    send_point(make_point(-0.1, 0.651));
    wait_drained();
  endtask

  // A limit of 0 acts as 1, values above 256 clip to 256, and a small
  // limit cuts points off early.
  task automatic test_limit_clipping();
    write_limit(9'd0);
    send_point(make_point(0.0, 0.0));
    send_point(make_point(-1.0, 0.0));
    send_point(make_point(1.9, 0.0));
    wait_drained();
    write_limit(9'd1);
    send_point(make_point(0.0, 0.0));
    wait_drained();
    write_limit(9'd511);
    send_point(make_point(0.0, 0.0));
    send_point(make_point(0.2, 0.0));
    wait_drained();
    write_limit(9'd257);
    send_point(make_point(-0.5, 0.5));
    wait_drained();
    write_limit(9'd2);
    send_point(make_point(0.25, 0.0));
    send_point(make_point(1.0, 0.0));           // z2 = 2, escapes at step 2
    wait_drained();
  endtask

  // Random points over a series of limits, with the idle shaping changed
  // per phase. Every so often the sender holds off until nothing is left.
  task automatic test_random_sweep();
    logic [MAXIT_W-1:0] phase_limit;
    int unsigned        phase, i;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       phase_limit = 9'd256;
        1:       phase_limit = 9'd40;
        2:       phase_limit = 9'd3;
        3:       phase_limit = 9'd100;
        4:       phase_limit = 9'd300;
        5:       phase_limit = 9'd256;
        default: phase_limit = 9'($urandom_range(0, 511));
      endcase
      write_limit(phase_limit);
      tx_gaps_on   = (phase % 3) != 0;
      rx_stalls_on = (phase % 2) != 0;
      for (i = 0; i < 80; i++) begin
        send_point(rand_point());
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
      wait_drained();
    end
  endtask

  // Sender pauses until all counts are back, then refills behind a
  // stalling receiver so a finished count waits on a full output register.
  task automatic test_pause_and_refill();
    int unsigned i;
    write_limit(9'd12);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b1;
    for (i = 0; i < 20; i++) send_point(rand_point());
    wait_drained();
    for (i = 0; i < 20; i++) send_point(rand_point());
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_limit_points();
    test_limit_clipping();
    test_random_sweep();
    test_pause_and_refill();

    wait_drained();
    mismatches += pending_counts.size();

    $display("covered %0d points over %0d limit writes; %0d counts checked, longest %0d",
             points_sent, limit_writes, counts_checked, longest_count);
    $display("limits 0, 1, 2, small, 256 and clipped values, with gaps and stalls");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mec_pkg.sv
rtl/mec_ctrl.sv
rtl/mec_datapath.sv
rtl/mandelbrot_escape_counter_top.sv
sim/tb_mandelbrot_escape_counter_top.sv
